// ===== rtl/mlse_pkg.sv =====
package mlse_pkg;

	// Register map
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_PEAK_VALUE   = 2'd0;
	localparam reg_idx_t REG_INVERSE_PEAK = 2'd1;
	localparam reg_idx_t REG_LOG2_GROWTH  = 2'd2;
	localparam reg_idx_t REG_PEAK_OVER_MU = 2'd3;

	// Register widths and reset values
	localparam int PEAK_W = 15;
	localparam int INV_W  = 31;
	localparam int LOG_W  = 29;
	localparam int POM_W  = 32;
	localparam logic [PEAK_W-1:0] PEAK_RESET = 15'd32767;
	localparam logic [INV_W-1:0]  INV_RESET  = 31'd32769;
	localparam logic [LOG_W-1:0]  LOG_RESET  = 29'd134217728;
	localparam logic [POM_W-1:0]  POM_RESET  = 32'd8421374;

	// Datapath formats
	localparam int OUT_W       = 16;
	localparam int MAG_W       = OUT_W - 1;
	localparam int R_SHIFT     = 14;  // a * (1/V) in Q.30 down to Q.16
	localparam int E_SHIFT     = 16;  // r * log2(1+mu) down to Q.24
	localparam int E_FRAC_W    = 24;
	localparam int N_W         = 5;   // exponent integer part that can still fit
	localparam int SPLIT_W     = 24;  // low slice of r for the split multiply
	localparam int ROM_W       = 32;  // table entries in Q2.30, at most 2^31
	localparam int P_W         = POM_W + ROM_W;
	localparam int WIDE_W      = 96;
	localparam int SCALE_SHIFT = 30;
	localparam int MAG_SHIFT   = 46;
	localparam logic [MAG_W-1:0] MAG_MAX = 15'd32767;

	// Integer square root, used only while building the exponent table
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bit_w;
		logic [63:0] rest;
		rest  = v;
		res   = '0;
		bit_w = 64'd1 << 62;
		for (int s = 0; s < 32; s++) begin
			if (bit_w > rest) begin
				bit_w = bit_w >> 2;
			end
		end
		for (int s = 0; s < 32; s++) begin
			if (bit_w != '0) begin
				if (rest >= res + bit_w) begin
					rest = rest - (res + bit_w);
					res  = (res >> 1) + bit_w;
				end else begin
					res = res >> 1;
				end
				bit_w = bit_w >> 2;
			end
		end
		return res;
	endfunction

	// Entry i of the 2^(i/2^tib) table in Q2.30
	function automatic logic [ROM_W-1:0] exp_entry(input int tib, input int i);
		logic [63:0] roots [13];
		logic [63:0] y;
		roots[0] = 64'd1 << 31;
		for (int k = 1; k < 13; k++) begin
			roots[k] = isqrt64(roots[k-1] << 30);
		end
		y = 64'd1 << 30;
		for (int k = 1; k <= tib; k++) begin
			if (((i >> (tib - k)) & 1) != 0) begin
				y = (y * roots[k] + (64'd1 << 29)) >> 30;
			end
		end
		if (i == (1 << tib)) begin
			y = 64'd1 << 31;
		end
		return y[ROM_W-1:0];
	endfunction

endpackage

// ===== rtl/mlse_in_if.sv =====
interface mlse_in_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/mlse_out_if.sv =====
interface mlse_out_if
	import mlse_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] expanded;
	logic                    ok;
	logic                    saturated;

	modport source (output valid, output expanded, output ok, output saturated, input ready);
	modport sink (input valid, input expanded, input ok, input saturated, output ready);
endinterface

// ===== rtl/mu_law_sample_expander.sv =====
// Continuous mu-law expander: each signed sample x becomes
// sign(x)*(V/mu)*((1+mu)^(|x|/V)-1), saturated to +/-32767, with ok low (and a zero
// result) while any of the four registers is zero. The datapath is a ten-stage
// pipeline built around four multipliers (sample by 1/V, a split multiply by
// log2(1+mu), table interpolation, scaling by V/mu) and an interpolated 2^f table of
// 2^TABLE_INDEX_BITS+1 constant entries. It takes one item per cycle while the
// output keeps up and returns each result from the last stage; each stage holds
// on its own, so a stall at the output is absorbed by empty stages before input
// ready drops. Registers may only be written while no item is in flight.
module mu_law_sample_expander
	import mlse_pkg::*;
#(
	parameter int TABLE_INDEX_BITS = 8,
	parameter int SAMPLE_BITS      = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	mlse_in_if.sink           samples,
	mlse_out_if.source        results
);

	localparam int TBL_N      = 1 << TABLE_INDEX_BITS;
	localparam int FRAC_SHIFT = E_FRAC_W - TABLE_INDEX_BITS;
	localparam int R_W        = SAMPLE_BITS + INV_W - R_SHIFT;
	localparam int RH_W       = R_W - SPLIT_W;
	localparam int PL_W       = SPLIT_W + LOG_W;
	localparam int PH_W       = RH_W + LOG_W;
	localparam int Q_W        = R_W + LOG_W;
	localparam int IP_W       = ROM_W + FRAC_SHIFT;

	// Configuration registers
	logic [PEAK_W-1:0] peak_value_q;
	logic [INV_W-1:0]  inverse_peak_q;
	logic [LOG_W-1:0]  log2_growth_q;
	logic [POM_W-1:0]  peak_over_mu_q;
	reg_idx_t          reg_idx;
	logic              cfg_write;
	logic              cfg_ok;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_ok    = (peak_value_q != '0) && (inverse_peak_q != '0) &&
		(log2_growth_q != '0) && (peak_over_mu_q != '0);

	// Write a register, masked to its width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_value_q   <= PEAK_RESET;
			inverse_peak_q <= INV_RESET;
			log2_growth_q  <= LOG_RESET;
			peak_over_mu_q <= POM_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_PEAK_VALUE:   peak_value_q   <= pwdata[PEAK_W-1:0];
				REG_INVERSE_PEAK: inverse_peak_q <= pwdata[INV_W-1:0];
				REG_LOG2_GROWTH:  log2_growth_q  <= pwdata[LOG_W-1:0];
				REG_PEAK_OVER_MU: peak_over_mu_q <= pwdata[POM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_PEAK_VALUE:   prdata = DATA_W'(peak_value_q);
			REG_INVERSE_PEAK: prdata = DATA_W'(inverse_peak_q);
			REG_LOG2_GROWTH:  prdata = DATA_W'(log2_growth_q);
			REG_PEAK_OVER_MU: prdata = DATA_W'(peak_over_mu_q);
			default:          prdata = '0;
		endcase
	end

	// Exponent table, built at elaboration
	logic [ROM_W-1:0] exp_rom [TBL_N+1];
	for (genvar g = 0; g <= TBL_N; g++) begin : g_rom
		localparam logic [ROM_W-1:0] ENTRY = exp_entry(TABLE_INDEX_BITS, g);
		assign exp_rom[g] = ENTRY;
	end

	// Stage valids and per-stage load enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;
	logic [10:1] load;

	assign load[10] = !valid_s10 || results.ready;
	assign load[9]  = !valid_s9 || load[10];
	assign load[8]  = !valid_s8 || load[9];
	assign load[7]  = !valid_s7 || load[8];
	assign load[6]  = !valid_s6 || load[7];
	assign load[5]  = !valid_s5 || load[6];
	assign load[4]  = !valid_s4 || load[5];
	assign load[3]  = !valid_s3 || load[4];
	assign load[2]  = !valid_s2 || load[3];
	assign load[1]  = !valid_s1 || load[2];
	assign samples.ready = load[1];

	// Advance valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			if (load[1]) valid_s1 <= samples.valid;
			if (load[2]) valid_s2 <= valid_s1;
			if (load[3]) valid_s3 <= valid_s2;
			if (load[4]) valid_s4 <= valid_s3;
			if (load[5]) valid_s5 <= valid_s4;
			if (load[6]) valid_s6 <= valid_s5;
			if (load[7]) valid_s7 <= valid_s6;
			if (load[8]) valid_s8 <= valid_s7;
			if (load[9]) valid_s9 <= valid_s8;
			if (load[10]) valid_s10 <= valid_s9;
		end
	end

	// Stage 1: sign and magnitude
	logic [SAMPLE_BITS-1:0] raw;
	logic [SAMPLE_BITS-1:0] mag_in;
	logic                   neg_s1;
	logic [SAMPLE_BITS-1:0] a_s1;

	assign raw    = SAMPLE_BITS'(unsigned'(samples.sample));
	assign mag_in = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + 1'b1) : raw;

	// Stage 2: ratio r = |x| / V in Q.16
	logic                    neg_s2;
	logic [R_W-1:0]          r_s2;
	logic [SAMPLE_BITS+INV_W-1:0] ratio_full;

	assign ratio_full = (SAMPLE_BITS+INV_W)'(a_s1) * (SAMPLE_BITS+INV_W)'(inverse_peak_q);

	// Stage 3: split product of r and log2(1+mu)
	logic            neg_s3;
	logic [PL_W-1:0] pl_s3;
	logic [PH_W-1:0] ph_s3;

	// Stage 4: exponent split into integer part, table index and remainder
	logic [Q_W-1:0]              q;
	logic                        neg_s4;
	logic                        sat_s4;
	logic [N_W-1:0]              n_s4;
	logic [TABLE_INDEX_BITS-1:0] idx_s4;
	logic [FRAC_SHIFT-1:0]       rem_s4;

	assign q = (Q_W'(ph_s3) << SPLIT_W) + Q_W'(pl_s3);

	// Stage 5: table lookup
	logic [TABLE_INDEX_BITS:0] idx_lo;
	logic [TABLE_INDEX_BITS:0] idx_hi;
	logic                      neg_s5;
	logic                      sat_s5;
	logic [N_W-1:0]            n_s5;
	logic [FRAC_SHIFT-1:0]     rem_s5;
	logic [ROM_W-1:0]          lo_s5;
	logic [ROM_W-1:0]          diff_s5;

	assign idx_lo = {1'b0, idx_s4};
	assign idx_hi = idx_lo + 1'b1;

	// Stage 6: interpolation product
	logic             neg_s6;
	logic             sat_s6;
	logic [N_W-1:0]   n_s6;
	logic [ROM_W-1:0] lo_s6;
	logic [IP_W-1:0]  ip_s6;

	// Stage 7: interpolated mantissa
	logic             neg_s7;
	logic             sat_s7;
	logic [N_W-1:0]   n_s7;
	logic [ROM_W-1:0] m_s7;

	// Stage 8: scale by V/mu
	logic              neg_s8;
	logic              sat_s8;
	logic [N_W-1:0]    n_s8;
	logic [P_W-1:0]    p_s8;
	logic [WIDE_W-1:0] c_s8;

	// Stage 9: apply integer exponent
	logic              neg_s9;
	logic              sat_s9;
	logic [WIDE_W-1:0] x_s9;
	logic [WIDE_W-1:0] c_s9;

	// Stage 10: subtract, round, clamp, sign
	logic [WIDE_W-1:0]       u;
	logic                    sat_all;
	logic [MAG_W-1:0]        mag;
	logic [OUT_W-1:0]        mag_ext;
	logic signed [OUT_W-1:0] expanded_s10;
	logic                    ok_s10;
	logic                    saturated_s10;

	assign u       = x_s9 + c_s9;
	assign sat_all = sat_s9 || (u[WIDE_W-1:MAG_SHIFT+MAG_W] != '0);
	assign mag     = sat_all ? MAG_MAX : u[MAG_SHIFT+MAG_W-1:MAG_SHIFT];
	assign mag_ext = {1'b0, mag};

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (load[1]) begin
			neg_s1 <= raw[SAMPLE_BITS-1];
			a_s1   <= mag_in;
		end
		if (load[2]) begin
			neg_s2 <= neg_s1;
			r_s2   <= ratio_full[SAMPLE_BITS+INV_W-1:R_SHIFT];
		end
		if (load[3]) begin
			neg_s3 <= neg_s2;
			pl_s3  <= PL_W'(r_s2[SPLIT_W-1:0]) * PL_W'(log2_growth_q);
			ph_s3  <= PH_W'(r_s2[R_W-1:SPLIT_W]) * PH_W'(log2_growth_q);
		end
		if (load[4]) begin
			neg_s4 <= neg_s3;
			// exponent of 32 or more always overflows the output
			sat_s4 <= (q >> (E_SHIFT + E_FRAC_W + N_W)) != '0;
			n_s4   <= q[E_SHIFT+E_FRAC_W+N_W-1:E_SHIFT+E_FRAC_W];
			idx_s4 <= q[E_SHIFT+E_FRAC_W-1:E_SHIFT+FRAC_SHIFT];
			rem_s4 <= q[E_SHIFT+FRAC_SHIFT-1:E_SHIFT];
		end
		if (load[5]) begin
			neg_s5  <= neg_s4;
			sat_s5  <= sat_s4;
			n_s5    <= n_s4;
			rem_s5  <= rem_s4;
			lo_s5   <= exp_rom[idx_lo];
			diff_s5 <= exp_rom[idx_hi] - exp_rom[idx_lo];
		end
		if (load[6]) begin
			neg_s6 <= neg_s5;
			sat_s6 <= sat_s5;
			n_s6   <= n_s5;
			lo_s6  <= lo_s5;
			ip_s6  <= IP_W'(diff_s5) * IP_W'(rem_s5);
		end
		if (load[7]) begin
			neg_s7 <= neg_s6;
			sat_s7 <= sat_s6;
			n_s7   <= n_s6;
			m_s7   <= lo_s6 + ip_s6[IP_W-1:FRAC_SHIFT];
		end
		if (load[8]) begin
			neg_s8 <= neg_s7;
			sat_s8 <= sat_s7;
			n_s8   <= n_s7;
			p_s8   <= P_W'(peak_over_mu_q) * P_W'(m_s7);
			// rounding offset minus the subtracted one, both in the wide format
			c_s8   <= (WIDE_W'(1) << (MAG_SHIFT - 1)) -
				(WIDE_W'(peak_over_mu_q) << SCALE_SHIFT);
		end
		if (load[9]) begin
			neg_s9 <= neg_s8;
			sat_s9 <= sat_s8;
			x_s9   <= WIDE_W'(p_s8) << n_s8;
			c_s9   <= c_s8;
		end
		if (load[10]) begin
			if (!cfg_ok) begin
				expanded_s10  <= '0;
				ok_s10        <= 1'b0;
				saturated_s10 <= 1'b0;
			end else begin
				expanded_s10  <= signed'(neg_s9 ? OUT_W'(~mag_ext + 1'b1) : mag_ext);
				ok_s10        <= 1'b1;
				saturated_s10 <= sat_all;
			end
		end
	end

	assign results.valid     = valid_s10;
	assign results.expanded  = expanded_s10;
	assign results.ok        = ok_s10;
	assign results.saturated = saturated_s10;

`ifndef ASSERT_OFF
	// An accepted item always occupies the first stage on the next edge
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> valid_s1)
		else $error("accepted item did not enter the pipeline");

	// An invalid configuration gives a clean zero result
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s10 && !ok_s10 |-> expanded_s10 == '0 && !saturated_s10)
		else $error("invalid configuration produced a nonzero result");

	// A saturated result sits at the symmetric limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s10 && saturated_s10 |->
		expanded_s10 == OUT_W'(32767) || expanded_s10 == -OUT_W'(32767))
		else $error("saturated result not at the limit");

	// The most negative code never leaves the block
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s10 |-> expanded_s10 != {1'b1, {(OUT_W-1){1'b0}}})
		else $error("result outside the symmetric range");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench
	import mlse_pkg::*;
();

	localparam int TIB         = 8;
	localparam int SBITS       = 16;
	localparam int LATENCY     = 10;
	localparam int HOLD_CYCLES = 100;

	typedef struct {
		logic signed [OUT_W-1:0] expanded;
		logic                    ok;
		logic                    saturated;
	} expansion_t;

	// Scoreboard: own copy of the register file, the 2^f table and the expected items
	class expander_scoreboard;
		logic [PEAK_W-1:0] peak;
		logic [INV_W-1:0]  inv_peak;
		logic [LOG_W-1:0]  growth;
		logic [POM_W-1:0]  peak_mu;
		logic [63:0]       pow2_frac [0:(1 << TIB)];
		expansion_t        expected_results [$];
		int                accepted;
		int                checked;
		int                saturated_seen;
		int                invalid_seen;
		int                mismatches;

		function new();
			logic [63:0] roots [0:TIB];
			logic [63:0] y;
			roots[0] = 64'd1 << 31;
			for (int k = 1; k <= TIB; k++) begin
				roots[k] = floor_sqrt(roots[k-1] << 30);
			end
			// multiply in the root for each set bit of the index, MSB first
			for (int i = 0; i < (1 << TIB); i++) begin
				y = 64'd1 << 30;
				for (int k = 1; k <= TIB; k++) begin
					if (((i >> (TIB - k)) & 1) != 0) begin
						y = (y * roots[k] + (64'd1 << 29)) >> 30;
					end
				end
				pow2_frac[i] = y;
			end
			pow2_frac[1 << TIB] = 64'd1 << 31;
			peak     = PEAK_RESET;
			inv_peak = INV_RESET;
			growth   = LOG_RESET;
			peak_mu  = POM_RESET;
		endfunction

		// bitwise search for the largest root whose square still fits
		function logic [63:0] floor_sqrt(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] cand;
			root = '0;
			for (int b = 31; b >= 0; b--) begin
				cand = root | (64'd1 << b);
				if (cand * cand <= v) begin
					root = cand;
				end
			end
			return root;
		endfunction

		function void set_register(reg_idx_t idx, logic [DATA_W-1:0] v);
			case (idx)
				REG_PEAK_VALUE: begin
					peak = v[PEAK_W-1:0];
				end
				REG_INVERSE_PEAK: begin
					inv_peak = v[INV_W-1:0];
				end
				REG_LOG2_GROWTH: begin
					growth = v[LOG_W-1:0];
				end
				default: begin
					peak_mu = v[POM_W-1:0];
				end
			endcase
		endfunction

		function logic [DATA_W-1:0] register_value(reg_idx_t idx);
			case (idx)
				REG_PEAK_VALUE: begin
					return DATA_W'(peak);
				end
				REG_INVERSE_PEAK: begin
					return DATA_W'(inv_peak);
				end
				REG_LOG2_GROWTH: begin
					return DATA_W'(growth);
				end
				default: begin
					return DATA_W'(peak_mu);
				end
			endcase
		endfunction

		// Expand one sample: exponent in Q.24, table lookup, scale, round, clamp
		function expansion_t expand_sample(logic signed [SBITS-1:0] s);
			expansion_t  res;
			logic        neg;
			logic        sat;
			logic [63:0] a, r, e, n, f, idx, rem, lo, hi, m, p, offset, big, mag;
			neg = s[SBITS-1];
			a   = neg ? 64'(-longint'(s)) : 64'(longint'(s));
			sat = 1'b0;
			mag = '0;
			if (peak == 0 || inv_peak == 0 || growth == 0 || peak_mu == 0) begin
				res.expanded  = '0;
				res.ok        = 1'b0;
				res.saturated = 1'b0;
				return res;
			end
			r = (a * inv_peak) >> 14;
			if (r > 64'hFFFF_FFFF_FFFF_FFFF / growth) begin
				sat = 1'b1;
			end else begin
				e   = (r * growth) >> 16;
				n   = e >> 24;
				f   = e & 64'hFF_FFFF;
				idx = f >> (24 - TIB);
				rem = f & ((64'd1 << (24 - TIB)) - 1);
				lo  = pow2_frac[int'(idx)];
				hi  = pow2_frac[int'(idx) + 1];
				m   = lo + (((hi - lo) * rem) >> (24 - TIB));
				p   = 64'(peak_mu) * m;
				offset = 64'(peak_mu) << 30;
				if (n >= 63 || p > (64'hFFFF_FFFF_FFFF_FFFF >> n)) begin
					sat = 1'b1;
				end else begin
					big = (p << n) - offset;
					if (big >= (64'd1 << 61) - (64'd1 << 45)) begin
						sat = 1'b1;
					end else begin
						mag = (big + (64'd1 << 45)) >> 46;
					end
				end
			end
			if (sat || mag > 64'd32767) begin
				sat = 1'b1;
				mag = 64'd32767;
			end
			res.expanded  = neg ? -OUT_W'(mag) : OUT_W'(mag);
			res.ok        = 1'b1;
			res.saturated = sat;
			return res;
		endfunction

		function void note_sample(logic signed [SBITS-1:0] s);
			expected_results.push_back(expand_sample(s));
			accepted++;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("tb: mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(logic signed [OUT_W-1:0] expanded, logic ok, logic saturated);
			expansion_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("result item with nothing expected");
				return;
			end
			want = expected_results.pop_front();
			checked++;
			if (want.saturated) saturated_seen++;
			if (!want.ok) invalid_seen++;
			if (expanded !== want.expanded) begin
				report_mismatch($sformatf("expanded %0d, expected %0d", expanded, want.expanded));
			end
			if (ok !== want.ok) begin
				report_mismatch($sformatf("ok %b, expected %b", ok, want.ok));
			end
			if (saturated !== want.saturated) begin
				report_mismatch($sformatf("saturated %b, expected %b", saturated, want.saturated));
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	mlse_in_if #(.SAMPLE_BITS(SBITS)) samples_if ();
	mlse_out_if                       results_if ();

	expander_scoreboard sb = new();

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int settings_used;
	bit hold_request;

	mu_law_sample_expander #(
		.TABLE_INDEX_BITS(TIB),
		.SAMPLE_BITS     (SBITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.samples(samples_if),
		.results(results_if)
	);

	always #5 clk = ~clk;

	// Check each accepted result item, then pick ready for the next edge
	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready) begin
			sb.check_result(results_if.expanded, results_if.ok, results_if.saturated);
		end
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Drop the run if it hangs
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic write_register(reg_idx_t idx, logic [DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(idx) * 4);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		sb.set_register(idx, v);
	endtask

	task automatic read_register(reg_idx_t idx, output logic [DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'(int'(idx) * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		v = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write all four registers, then read them back
	task automatic write_registers(logic [DATA_W-1:0] peak, logic [DATA_W-1:0] inv,
			logic [DATA_W-1:0] grow, logic [DATA_W-1:0] pom);
		logic [DATA_W-1:0] got;
		write_register(REG_PEAK_VALUE, peak);
		write_register(REG_INVERSE_PEAK, inv);
		write_register(REG_LOG2_GROWTH, grow);
		write_register(REG_PEAK_OVER_MU, pom);
		for (int i = 0; i < 4; i++) begin
			read_register(reg_idx_t'(i), got);
			if (got !== sb.register_value(reg_idx_t'(i))) begin
				sb.report_mismatch($sformatf("register %0d reads %0h, expected %0h",
					i, got, sb.register_value(reg_idx_t'(i))));
			end
		end
		settings_used++;
	endtask

	// Derive the fixed-point registers from peak V and mu
	task automatic apply_law(int v, real mu);
		real inv_r, grow_r, pom_r;
		inv_r  = $floor(1073741824.0 / v);
		grow_r = $floor($ln(1.0 + mu) / $ln(2.0) * 16777216.0);
		pom_r  = $floor(v / mu * 65536.0);
		if (pom_r > 4294967295.0) pom_r = 4294967295.0;
		write_registers(DATA_W'(v), DATA_W'(longint'(inv_r)), DATA_W'(longint'(grow_r)),
			DATA_W'(longint'(pom_r)));
	endtask

	task automatic send_sample(logic signed [SBITS-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid  <= 1'b1;
		samples_if.sample <= s;
		do @(posedge clk); while (!samples_if.ready);
		sb.note_sample(s);
	endtask

	// Mix of full-range noise, nominal range, small values and values near the peak
	function automatic logic signed [SBITS-1:0] pick_sample(int peak);
		int sel;
		int mag;
		sel = $urandom_range(99);
		if (sel < 30) begin
			return SBITS'($urandom);
		end else if (sel < 70) begin
			mag = $urandom_range(peak, 0);
		end else if (sel < 85) begin
			mag = $urandom_range(64, 0);
		end else begin
			mag = peak + $urandom_range(8, 0) - 4;
		end
		if (mag < 0) mag = 0;
		if ($urandom_range(1)) begin
			if (mag > 32768) mag = 32768;
			return SBITS'(-mag);
		end
		if (mag > 32767) mag = 32767;
		return SBITS'(mag);
	endfunction

	// Stream random items under one idling mode, then drain
	task automatic run_phase(int count, int mode, bit with_hold);
		send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 88 : 0;
		recv_idle_pct = (mode == 0) ? 88 : (mode == 1) ? 22 : 0;
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == 20) hold_request = 1'b1;
			send_sample(pick_sample(int'(sb.peak)));
		end
		samples_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		logic signed [SBITS-1:0] corner_samples [$];
		corner_samples = '{0, 1, -1, 2, -2, 100, -100, 1000, -1000, 255, 256, 8192,
			16384, -16384, 21845, -21846, 32766, -32767, 32767, -32768};
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		samples_if.valid  = 1'b0;
		samples_if.sample = '0;
		results_if.ready  = 1'b0;
		send_idle_pct     = 0;
		recv_idle_pct     = 0;
		hold_left         = 0;
		hold_request      = 1'b0;
		settings_used     = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: corner samples first, then random
		send_idle_pct = 22;
		recv_idle_pct = 88;
		foreach (corner_samples[i]) send_sample(corner_samples[i]);
		run_phase(150, 0, 1'b0);

		apply_law(8000, 100.0);
		run_phase(150, 0, 1'b0);
		// Smallest peak and largest 1/V: almost everything saturates
		apply_law(1, 1.0);
		run_phase(60, 0, 1'b0);
		// Large growth and largest scale: intermediate overflow
		write_registers(DATA_W'(PEAK_RESET), DATA_W'(INV_RESET), 32'd268435456, 32'hFFFF_FFFF);
		run_phase(120, 0, 1'b0);
		apply_law(100, 0.5);
		run_phase(120, 1, 1'b0);
		apply_law(32767, 1.0);
		run_phase(120, 1, 1'b0);

		// Each register zero in turn marks the settings invalid
		write_registers(32'd0, DATA_W'(INV_RESET), DATA_W'(LOG_RESET), DATA_W'(POM_RESET));
		run_phase(25, 1, 1'b0);
		write_registers(DATA_W'(PEAK_RESET), 32'd0, DATA_W'(LOG_RESET), DATA_W'(POM_RESET));
		run_phase(25, 1, 1'b0);
		write_registers(DATA_W'(PEAK_RESET), DATA_W'(INV_RESET), 32'd0, DATA_W'(POM_RESET));
		run_phase(25, 1, 1'b0);
		write_registers(DATA_W'(PEAK_RESET), DATA_W'(INV_RESET), DATA_W'(LOG_RESET), 32'd0);
		run_phase(25, 1, 1'b0);

		apply_law($urandom_range(32767, 1), $urandom_range(2000, 1) / 4.0);
		run_phase(120, 2, 1'b0);
		write_registers(DATA_W'($urandom_range(32767, 1)), DATA_W'($urandom_range(1 << 30, 1)),
			DATA_W'($urandom_range(1 << 28, 1)), DATA_W'($urandom));
		run_phase(80, 2, 1'b0);
		// Long output stall while the input keeps offering items
		apply_law(32767, 255.0);
		run_phase(200, 2, 1'b1);

		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 6) @(posedge clk);
		$display("tb: %0d samples over %0d register settings, %0d results checked",
			sb.accepted, settings_used, sb.checked);
		$display("tb: %0d saturated results, %0d with invalid settings, %0d mismatches",
			sb.saturated_seen, sb.invalid_seen, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
